### hdl/gnd_pkg.sv
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared types, codes and denomination tables for the note dispenser.
// ----------------------------------------------------------------------------
package gnd_pkg;

	// number of real denominations, largest first
	localparam int NUM_FACES = 9;

	// largest value shown on the total output
	localparam logic [25:0] TOTAL_MAX = 26'h3FF_FFFF;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVER     = 2'd1,
		ST_LOW      = 2'd2,
		ST_NOEXACT  = 2'd3
	} status_t;

	// operation codes
	typedef enum logic {
		OP_WITHDRAW = 1'b0,
		OP_DEPOSIT  = 1'b1
	} op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    load;
		logic    deposit;
		logic    sum_clr;
		logic    sum_en;
		logic    trial_load;
		logic    mul_a;
		logic    mul_b;
		logic    step;
		logic    commit;
		logic    st_set;
		status_t st_val;
		logic    out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic op_dep;
		logic over_limit;
		logic too_low;
		logic rest_zero;
		logic out_free;
	} sts_t;

	// face value of a slot; slots past the real ones are worth nothing
	function automatic logic [8:0] face_val(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0: v = 9'd500;
			4'd1: v = 9'd200;
			4'd2: v = 9'd100;
			4'd3: v = 9'd50;
			4'd4: v = 9'd20;
			4'd5: v = 9'd10;
			4'd6: v = 9'd5;
			4'd7: v = 9'd2;
			4'd8: v = 9'd1;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// floor(2^31 / face value), used to divide the remainder by a face value
	function automatic logic [31:0] recip_val(input logic [3:0] idx);
		logic [31:0] r;
		case (idx)
			4'd0: r = 32'd4294967;
			4'd1: r = 32'd10737418;
			4'd2: r = 32'd21474836;
			4'd3: r = 32'd42949672;
			4'd4: r = 32'd107374182;
			4'd5: r = 32'd214748364;
			4'd6: r = 32'd429496729;
			4'd7: r = 32'd1073741824;
			4'd8: r = 32'd2147483648;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/gnd_if.sv
// ----------------------------------------------------------------------------
// gnd_if
// Request and response channels of the note dispenser.
// ----------------------------------------------------------------------------
interface gnd_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [23:0] amount;
	logic [23:0] card_limit;
	logic [8:0]  note_value;
	logic [7:0]  quantity;

	modport source (output valid, operation, amount, card_limit, note_value, quantity,
		input ready);
	modport sink (input valid, operation, amount, card_limit, note_value, quantity,
		output ready);
endinterface

interface gnd_rsp_if;
	logic        valid;
	logic        ready;
	logic [23:0] paid_amount;
	logic [1:0]  status;
	logic [25:0] total_held;

	modport source (output valid, paid_amount, status, total_held, input ready);
	modport sink (input valid, paid_amount, status, total_held, output ready);
endinterface

### hdl/gnd_ctrl.sv
// ----------------------------------------------------------------------------
// gnd_ctrl
// Sequencer: total walk, deposit, limit checks, greedy walk, commit and result load.
// ----------------------------------------------------------------------------
module gnd_ctrl #(
	parameter int ACTIVE = 9,
	parameter int IW     = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  gnd_pkg::sts_t  sts,
	output gnd_pkg::cmd_t  cmd,
	output logic [IW-1:0]  idx
);
	import gnd_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DEP   = 9'b000000010,
		S_SUM   = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_WA    = 9'b000010000,
		S_WB    = 9'b000100000,
		S_WC    = 9'b001000000,
		S_FIN   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	localparam logic [IW-1:0] LAST = IW'(ACTIVE - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic          post_q, post_d;

	assign req_ready = (state_q == S_IDLE);
	assign idx       = idx_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		post_d  = post_q;
		cmd     = '0;
		cmd.st_val = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load    = 1'b1;
					cmd.sum_clr = 1'b1;
					idx_d       = '0;
					post_d      = 1'b0;
					state_d     = S_SUM;
				end
			end
			S_DEP: begin
				cmd.deposit = 1'b1;
				cmd.sum_clr = 1'b1;
				idx_d       = '0;
				post_d      = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				if (idx_q == LAST) begin
					if (post_q) begin
						state_d = S_OUT;
					end else if (sts.op_dep) begin
						state_d = S_DEP;
					end else begin
						state_d = S_CHECK;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_CHECK: begin
				if (sts.over_limit) begin
					cmd.st_set = 1'b1;
					cmd.st_val = ST_OVER;
					state_d    = S_OUT;
				end else if (sts.too_low) begin
					cmd.st_set = 1'b1;
					cmd.st_val = ST_LOW;
					state_d    = S_OUT;
				end else begin
					cmd.trial_load = 1'b1;
					idx_d          = '0;
					state_d        = S_WA;
				end
			end
			S_WA: begin
				cmd.mul_a = 1'b1;
				state_d   = S_WB;
			end
			S_WB: begin
				cmd.mul_b = 1'b1;
				state_d   = S_WC;
			end
			S_WC: begin
				cmd.step = 1'b1;
				if (idx_q == LAST) begin
					state_d = S_FIN;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_WA;
				end
			end
			S_FIN: begin
				if (sts.rest_zero) begin
					cmd.commit  = 1'b1;
					cmd.sum_clr = 1'b1;
					idx_d       = '0;
					post_d      = 1'b1;
					state_d     = S_SUM;
				end else begin
					cmd.st_set = 1'b1;
					cmd.st_val = ST_NOEXACT;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			post_q  <= post_d;
		end
	end

endmodule

### hdl/gnd_dpath.sv
// ----------------------------------------------------------------------------
// gnd_dpath
// Note counts, total accumulator, greedy divide unit and result register.
// ----------------------------------------------------------------------------
module gnd_dpath #(
	parameter int ACTIVE = 9,
	parameter int IW     = 4,
	parameter int CW     = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gnd_pkg::cmd_t  cmd,
	input  logic [IW-1:0]  idx,
	output gnd_pkg::sts_t  sts,
	gnd_req_if.sink        req,
	gnd_rsp_if.source      rsp
);
	import gnd_pkg::*;

	localparam int TW   = (CW + 13 > 26) ? CW + 13 : 26;
	localparam int CMPW = (CW > 25) ? CW : 25;

	// latched request
	logic        op_q;
	logic [23:0] amount_q;
	logic [23:0] limit_q;
	logic [8:0]  value_q;
	logic [7:0]  qty_q;

	// inventory and trial copy
	logic [CW-1:0] counts_q [ACTIVE];
	logic [CW-1:0] trial_q  [ACTIVE];
	logic [CW-1:0] dep_next [ACTIVE];

	// walk registers
	logic [TW-1:0]  sum_q;
	logic [23:0]    rest_q;
	logic [55:0]    prod_q;
	logic [CW+8:0]  cv_q;
	logic [23:0]    qe_q;
	logic [23:0]    r_q;
	status_t        st_q;

	// result register
	logic        out_valid_q;
	logic [23:0] paid_q;
	status_t     status_q;
	logic [25:0] total_q;

	logic [8:0]     v;
	logic [CW-1:0]  cnt;
	logic [32:0]    qv;
	logic           ge;
	logic [24:0]    q_c;
	logic [23:0]    r_c;
	logic           fits;

	assign v   = face_val(4'(idx));
	assign cnt = trial_q[idx];

	// remainder correction of the reciprocal estimate
	assign qv   = 33'(prod_q[54:31]) * 33'(v);
	assign ge   = (r_q >= 24'(v));
	assign q_c  = {1'b0, qe_q} + 25'(ge);
	assign r_c  = ge ? (r_q - 24'(v)) : r_q;
	assign fits = (CMPW'(q_c) <= CMPW'(cnt));

	// saturating deposit per slot
	always_comb begin
		for (int j = 0; j < ACTIVE; j++) begin
			logic [CW:0] s;
			s = {1'b0, counts_q[j]} + (CW+1)'(qty_q);
			if (face_val(4'(j)) == value_q && value_q != 9'd0) begin
				dep_next[j] = s[CW] ? {CW{1'b1}} : s[CW-1:0];
			end else begin
				dep_next[j] = counts_q[j];
			end
		end
	end

	// status to controller
	assign sts.op_dep     = (op_q == OP_DEPOSIT);
	assign sts.over_limit = (amount_q > limit_q);
	assign sts.too_low    = (sum_q < TW'(amount_q));
	assign sts.rest_zero  = (rest_q == 24'd0);
	assign sts.out_free   = !out_valid_q || rsp.ready;

	// note counts: deposit and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ACTIVE; j++) begin
				counts_q[j] <= CW'(1);
			end
		end else if (cmd.deposit) begin
			counts_q <= dep_next;
		end else if (cmd.commit) begin
			counts_q <= trial_q;
		end
	end

	// request latch, accumulator and greedy walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.operation;
			amount_q <= req.amount;
			limit_q  <= req.card_limit;
			value_q  <= req.note_value;
			qty_q    <= req.quantity;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_en) begin
			sum_q <= sum_q + TW'(v) * TW'(counts_q[idx]);
		end
		if (cmd.load) begin
			st_q <= ST_OK;
		end else if (cmd.st_set) begin
			st_q <= cmd.st_val;
		end
		if (cmd.trial_load) begin
			trial_q <= counts_q;
			rest_q  <= amount_q;
		end
		if (cmd.mul_a) begin
			prod_q <= 56'(rest_q) * 56'(recip_val(4'(idx)));
			cv_q   <= (CW+9)'(cnt) * (CW+9)'(v);
		end
		if (cmd.mul_b) begin
			qe_q <= prod_q[54:31];
			r_q  <= rest_q - qv[23:0];
		end
		if (cmd.step) begin
			if (fits) begin
				trial_q[idx] <= cnt - CW'(q_c);
				rest_q       <= r_c;
			end else begin
				trial_q[idx] <= '0;
				rest_q       <= rest_q - 24'(cv_q);
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			paid_q   <= (op_q == OP_WITHDRAW && st_q == ST_OK) ? amount_q : 24'd0;
			status_q <= st_q;
			total_q  <= (sum_q > TW'(TOTAL_MAX)) ? TOTAL_MAX : sum_q[25:0];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.paid_amount = paid_q;
	assign rsp.status      = status_q;
	assign rsp.total_held  = total_q;

endmodule

### hdl/greedy_note_dispenser.sv
// ----------------------------------------------------------------------------
// greedy_note_dispenser
// Cash dispenser with a limited note inventory and greedy payout.
// ----------------------------------------------------------------------------
// Usage: items arrive on req (valid/ready) and one result per item leaves on
// rsp (valid/ready). A withdraw item is checked against its card limit, then
// against the total held, then paid out greedily from the largest note down;
// only an exact payout changes the counts. A deposit item adds notes to the
// matching denomination, saturating at the count width.
// One item is worked on at a time; req.ready is high only while the
// sequencer is idle. The active slots are the first min(NUM_DENOMS, 9)
// denominations. Each item walks the counts to form the total held (one
// multiply-accumulate per slot); a deposit or an exact payout walks them
// again after the counts change. The greedy walk takes each slot through
// the reciprocal multiply, the remainder and its correction, and the
// count step. The result sits in an output register; the next item can
// be taken in the cycle after the result is loaded, while it waits, and
// the sequencer holds a finished result until rsp frees.
// Reset sets every count to one note and empties the output register.
// ----------------------------------------------------------------------------
module greedy_note_dispenser #(
	parameter int NUM_DENOMS  = 9,
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gnd_req_if.sink    req,
	gnd_rsp_if.source  rsp
);
	import gnd_pkg::*;

	localparam int ACTIVE = (NUM_DENOMS < NUM_FACES) ? NUM_DENOMS : NUM_FACES;
	localparam int IW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] idx;

	// sequencer
	gnd_ctrl #(
		.ACTIVE (ACTIVE),
		.IW     (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	// datapath
	gnd_dpath #(
		.ACTIVE (ACTIVE),
		.IW     (IW),
		.CW     (COUNT_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.idx    (idx),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

### hdl/gnd_checker.sv
// ----------------------------------------------------------------------------
// gnd_checker
// Port-level checks of the note dispenser, bound to the top level.
// ----------------------------------------------------------------------------
module gnd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [23:0] paid_amount,
	input logic [1:0]  status,
	input logic [25:0] total_held
);
	import gnd_pkg::*;

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(paid_amount) && $stable(status)
			&& $stable(total_held))
		else $error("result payload changed while stalled");

	// failures never dispense
	a_fail_unpaid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> paid_amount == 24'd0)
		else $error("failed withdrawal shows a paid amount");

	// one item at a time: ready drops after an accepted item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while busy");

endmodule

bind greedy_note_dispenser gnd_checker u_gnd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.paid_amount (rsp.paid_amount),
	.status      (rsp.status),
	.total_held  (rsp.total_held)
);
